// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the RTL top of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on the rising edge of clk and held off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on the rising edge of clk, during reset as well.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/rmmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmmd_pkg
// Types and constants of the register-mapped multiply and divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmd_pkg;

  localparam int unsigned OffsetW = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 4;

  localparam logic [OffsetW-1:0] OFF_MPY_A  = 5'h02;
  localparam logic [OffsetW-1:0] OFF_MPY_B  = 5'h03;
  localparam logic [OffsetW-1:0] OFF_DIV_LO = 5'h04;
  localparam logic [OffsetW-1:0] OFF_DIV_HI = 5'h05;
  localparam logic [OffsetW-1:0] OFF_DIV_B  = 5'h06;
  localparam logic [OffsetW-1:0] OFF_QUO_LO = 5'h14;
  localparam logic [OffsetW-1:0] OFF_QUO_HI = 5'h15;
  localparam logic [OffsetW-1:0] OFF_RES_LO = 5'h16;
  localparam logic [OffsetW-1:0] OFF_RES_HI = 5'h17;

  localparam logic [WordW-1:0]  QUO_ZERO_DIV = 16'hFFFF;
  localparam logic [CountW-1:0] DIV_LAST     = 4'hF;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_start;
    logic div_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/rmmd_datapath.sv =====
// ----------------------------------------------------------------------------
// rmmd_datapath
// Operand, quotient and result registers, the multiplier, the one-bit-a-cycle
// restoring divider and the read byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rmmd_pkg::dp_cmd_t             cmd,
  output rmmd_pkg::dp_sts_t                  sts,
  input  wire rmmd_pkg::op_t                 operation,
  input  wire logic [rmmd_pkg::OffsetW-1:0]  reg_offset,
  input  wire logic [rmmd_pkg::ByteW-1:0]    write_data,
  output logic [rmmd_pkg::ByteW-1:0]         read_data
);
  import rmmd_pkg::*;

  logic [ByteW-1:0]  multiplicand_r, multiplicand_nxt;
  logic [WordW-1:0]  dividend_r, dividend_nxt;
  logic [WordW-1:0]  quotient_r, quotient_nxt;
  logic [WordW-1:0]  prod_rem_r, prod_rem_nxt;
  logic [ByteW-1:0]  divisor_r, divisor_nxt;
  logic [ByteW-1:0]  part_rem_r, part_rem_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [ByteW-1:0]  rdata_r, rdata_nxt;

  logic [WordW-1:0]  product;
  logic [ByteW:0]    shifted;
  logic [ByteW:0]    diff;
  logic              fits;
  logic [ByteW-1:0]  new_rem;
  logic [ByteW-1:0]  read_byte;

  assign product = WordW'(multiplicand_r) * WordW'(write_data);

  assign shifted = {part_rem_r, quotient_r[WordW-1]};
  assign diff    = shifted - {1'b0, divisor_r};
  assign fits    = shifted >= {1'b0, divisor_r};
  assign new_rem = fits ? diff[ByteW-1:0] : shifted[ByteW-1:0];

  assign sts.div_start = (operation == OP_WRITE) && (reg_offset == OFF_DIV_B)
                         && (write_data != '0);
  assign sts.div_last  = (count_r == DIV_LAST);

  always_comb begin
    unique case (reg_offset)
      OFF_QUO_LO: read_byte = quotient_r[ByteW-1:0];
      OFF_QUO_HI: read_byte = quotient_r[WordW-1:ByteW];
      OFF_RES_LO: read_byte = prod_rem_r[ByteW-1:0];
      OFF_RES_HI: read_byte = prod_rem_r[WordW-1:ByteW];
      default:    read_byte = '0;
    endcase
  end

  always_comb begin
    multiplicand_nxt = multiplicand_r;
    dividend_nxt     = dividend_r;
    quotient_nxt     = quotient_r;
    prod_rem_nxt     = prod_rem_r;
    divisor_nxt      = divisor_r;
    part_rem_nxt     = part_rem_r;
    count_nxt        = count_r;
    rdata_nxt        = rdata_r;

    if (cmd.load) begin
      rdata_nxt = (operation == OP_READ) ? read_byte : '0;
      if (operation == OP_WRITE) begin
        unique case (reg_offset)
          OFF_MPY_A:  multiplicand_nxt = write_data;
          OFF_MPY_B:  prod_rem_nxt = product;
          OFF_DIV_LO: dividend_nxt[ByteW-1:0] = write_data;
          OFF_DIV_HI: dividend_nxt[WordW-1:ByteW] = write_data;
          OFF_DIV_B: begin
            if (write_data == '0) begin
              quotient_nxt = QUO_ZERO_DIV;
              prod_rem_nxt = dividend_r;
            end else begin
              quotient_nxt = dividend_r;
              divisor_nxt  = write_data;
              part_rem_nxt = '0;
              count_nxt    = '0;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd.div_step) begin
      quotient_nxt = {quotient_r[WordW-2:0], fits};
      part_rem_nxt = new_rem;
      count_nxt    = count_r + 1'b1;
    end

    if (cmd.div_finish) begin
      prod_rem_nxt = {{(WordW-ByteW){1'b0}}, new_rem};
      rdata_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      multiplicand_r <= '0;
      dividend_r     <= '0;
      quotient_r     <= '0;
      prod_rem_r     <= '0;
      count_r        <= '0;
    end else begin
      multiplicand_r <= multiplicand_nxt;
      dividend_r     <= dividend_nxt;
      quotient_r     <= quotient_nxt;
      prod_rem_r     <= prod_rem_nxt;
      count_r        <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r  <= divisor_nxt;
    part_rem_r <= part_rem_nxt;
    rdata_r    <= rdata_nxt;
  end

  assign read_data = rdata_r;

endmodule

`default_nettype wire

// ===== design/rmmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmmd_ctrl
// Controller: takes requests, sequences the sixteen divide steps and owns the
// result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rmmd_pkg::dp_cmd_t       cmd,
  input  wire rmmd_pkg::dp_sts_t  sts
);
  import rmmd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    take           = 1'b0;
    cmd            = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        take     = in_valid && in_ready;
        cmd.load = take;
        if (take) begin
          if (sts.div_start) begin
            state_nxt = ST_DIVIDE;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.div_finish = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/register_mapped_multiply_divide_top.sv =====
// ----------------------------------------------------------------------------
// register_mapped_multiply_divide_top
// Byte-wide register access unit with an 8x8 multiplier and a 16/8 divider.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata                          tuser
// in_      slave      [4:0] reg_offset [12:5] data   [0] operation
// out_     master     [7:0] read_data                none
//
// A read or any write other than a nonzero divisor gives its result in the cycle after it is taken.
// A nonzero divisor write is loaded and then runs sixteen
// restoring divide steps, one quotient bit per cycle.
// The result byte sits in an output register; a new request is taken
// while it is being handed over.
// Reset clears the multiplicand, dividend, quotient and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module register_mapped_multiply_divide_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [4:0] reg_offset, [12:5] write_data
  input  wire logic [0:0]  in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [7:0] read_data
);
  import rmmd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  op_t     operation;

  assign operation = op_t'(in_tuser[0]);

  rmmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rmmd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (operation),
    .reg_offset (in_tdata[OffsetW-1:0]),
    .write_data (in_tdata[OffsetW+ByteW-1:OffsetW]),
    .read_data  (out_tdata)
  );

  `ASSERT_CLK(a_no_request_while_dividing, cmd.div_step |-> !in_tready, "request taken during divide")
  `ASSERT_CLK(a_divide_ends_with_result, cmd.div_finish |=> (out_tvalid && out_tdata == '0), "divide end gave no zero result")
  `ASSERT_CLK(a_short_request_gives_result, (in_tvalid && in_tready && !sts.div_start) |=> out_tvalid, "short request gave no result")
  `ASSERT_CLK_ALWAYS(a_no_step_during_load, !(cmd.load && cmd.div_step), "load and divide step together")

endmodule

`default_nettype wire

// ===== bench/rmmd_checker.sv =====
// ----------------------------------------------------------------------------
// rmmd_checker
// Watches both streams of the multiply and divide unit. It keeps its own copy
// of the operand and result registers, works out the byte that each accepted
// request must return, and compares every returned byte with the oldest one
// that is still waiting.
// ----------------------------------------------------------------------------
module rmmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] reg_offset, [12:5] write_data
  input  logic [0:0]  in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] read_data
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmmd_pkg::*;

  logic [ByteW-1:0] mcand_q;
  logic [WordW-1:0] dividend_q;
  logic [WordW-1:0] quotient_q;
  logic [WordW-1:0] prod_rem_q;
  logic [ByteW-1:0] expected_bytes[$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(string detail);
    if (mismatches < 100) begin
      $display("%0t ns: %s", $realtime, detail);
    end
    mismatches++;
  endtask

  function automatic logic [ByteW-1:0] apply_request(op_t op, logic [OffsetW-1:0] off,
                                                     logic [ByteW-1:0] data);
    logic [ByteW-1:0] rd;
    rd = '0;
    if (op == OP_WRITE) begin
      case (off)
        OFF_MPY_A:  mcand_q = data;
        OFF_MPY_B:  prod_rem_q = {8'd0, mcand_q} * {8'd0, data};
        OFF_DIV_LO: dividend_q[7:0] = data;
        OFF_DIV_HI: dividend_q[15:8] = data;
        OFF_DIV_B: begin
          if (data == '0) begin
            quotient_q = QUO_ZERO_DIV;
            prod_rem_q = dividend_q;
          end else begin
            quotient_q = dividend_q / {8'd0, data};
            prod_rem_q = dividend_q % {8'd0, data};
          end
        end
        default: ;
      endcase
    end else begin
      case (off)
        OFF_QUO_LO: rd = quotient_q[7:0];
        OFF_QUO_HI: rd = quotient_q[15:8];
        OFF_RES_LO: rd = prod_rem_q[7:0];
        OFF_RES_HI: rd = prod_rem_q[15:8];
        default:    rd = '0;
      endcase
    end
    return rd;
  endfunction

  always @(posedge clk) begin
    logic [ByteW-1:0] want;
    if (!rst_n) begin
      mcand_q    = '0;
      dividend_q = '0;
      quotient_q = '0;
      prod_rem_q = '0;
      expected_bytes.delete();
    end else begin
      // The returned byte always belongs to an older request, so it is
      // checked before a request taken at the same edge is added.
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("read_data 0x%02h returned with no request waiting",
                                    out_tdata));
        end else begin
          want = expected_bytes.pop_front();
          results_checked++;
          if (out_tdata !== want) begin
            report_mismatch($sformatf("read_data is 0x%02h, expected 0x%02h",
                                      out_tdata, want));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_bytes.push_back(apply_request(op_t'(in_tuser[0]), in_tdata[4:0],
                                               in_tdata[12:5]));
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

// ===== bench/register_mapped_multiply_divide_top_tb.sv =====
// ----------------------------------------------------------------------------
// register_mapped_multiply_divide_top_tb
// Drives byte register requests into the multiply and divide unit: a directed
// pass over the operand extremes, a zero divisor and unmapped offsets, then
// random multiply and divide sequences mixed with random requests, with
// random idle cycles on both streams. Checking is done by rmmd_checker.
// ----------------------------------------------------------------------------
module register_mapped_multiply_divide_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmmd_pkg::*;

  localparam logic [OffsetW-1:0] OFF_NONE_LO = 5'h00;
  localparam logic [OffsetW-1:0] OFF_NONE_HI = 5'h1F;
  localparam int unsigned        RANDOM_REQUESTS = 900;
  localparam int unsigned        QUIET_TAIL      = 100;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned requests_sent  = 0;
  int unsigned divides_sent   = 0;
  int unsigned zero_divisors  = 0;
  int unsigned multiplies_sent = 0;
  bit          idle_on        = 1'b1;
  bit          quiet_tail     = 1'b0;

  always #5 clk = ~clk;

  register_mapped_multiply_divide_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rmmd_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  task automatic send_request(op_t op, logic [OffsetW-1:0] off, logic [ByteW-1:0] data);
    if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, data, off};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
    if (op == OP_WRITE && off == OFF_DIV_B) begin
      divides_sent++;
      if (data == '0) zero_divisors++;
    end
    if (op == OP_WRITE && off == OFF_MPY_B) multiplies_sent++;
  endtask

  task automatic read_results();
    send_request(OP_READ, OFF_QUO_LO, ByteW'($urandom));
    send_request(OP_READ, OFF_QUO_HI, ByteW'($urandom));
    send_request(OP_READ, OFF_RES_LO, ByteW'($urandom));
    send_request(OP_READ, OFF_RES_HI, ByteW'($urandom));
  endtask

  task automatic multiply_sequence(logic [ByteW-1:0] a, logic [ByteW-1:0] b);
    send_request(OP_WRITE, OFF_MPY_A, a);
    send_request(OP_WRITE, OFF_MPY_B, b);
    send_request(OP_READ, OFF_RES_LO, ByteW'($urandom));
    send_request(OP_READ, OFF_RES_HI, ByteW'($urandom));
  endtask

  task automatic divide_sequence(logic [WordW-1:0] dividend, logic [ByteW-1:0] divisor,
                                 bit partial);
    if (!partial || $urandom_range(0, 1) == 0) send_request(OP_WRITE, OFF_DIV_LO, dividend[7:0]);
    if (!partial || $urandom_range(0, 1) == 0) send_request(OP_WRITE, OFF_DIV_HI, dividend[15:8]);
    send_request(OP_WRITE, OFF_DIV_B, divisor);
    read_results();
  endtask

  initial begin
    logic [ByteW-1:0] divisor;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: reset values, operand extremes, zero divisor,
    // unmapped offsets and reads of write-only offsets.
    send_request(OP_READ, OFF_QUO_HI, 8'hFF);
    send_request(OP_READ, OFF_RES_LO, 8'h00);
    multiply_sequence(8'hFF, 8'hFF);
    multiply_sequence(8'h00, 8'hA5);
    divide_sequence(16'hFFFF, 8'h01, 1'b0);
    divide_sequence(16'hFFFF, 8'hFF, 1'b0);
    divide_sequence(16'h1234, 8'h00, 1'b0);
    send_request(OP_WRITE, OFF_NONE_LO, 8'h55);
    send_request(OP_WRITE, OFF_QUO_LO, 8'hAA);
    send_request(OP_READ, OFF_NONE_HI, 8'hFF);
    send_request(OP_READ, OFF_MPY_A, 8'h00);
    read_results();

    while (requests_sent < RANDOM_REQUESTS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (requests_sent + QUIET_TAIL >= RANDOM_REQUESTS) quiet_tail = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: multiply_sequence(ByteW'($urandom), ByteW'($urandom));
        4, 5, 6, 7: begin
          divisor = ($urandom_range(0, 7) == 0) ? 8'h00 : ByteW'($urandom);
          divide_sequence(WordW'($urandom), divisor, $urandom_range(0, 3) == 0);
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            send_request(op_t'($urandom_range(0, 1)), OffsetW'($urandom),
                         ByteW'($urandom));
          end
        end
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests with %0d multiplies and %0d divides (%0d by zero).",
             requests_sent, multiplies_sent, divides_sent, zero_divisors);
    $display("Checked %0d returned bytes.", results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rmmd_pkg.sv
design/rmmd_datapath.sv
design/rmmd_ctrl.sv
design/register_mapped_multiply_divide_top.sv
bench/rmmd_checker.sv
bench/register_mapped_multiply_divide_top_tb.sv
